// ===== sv/dfss_pkg.sv =====
// ----------------------------------------------------------------------------
// dfss_pkg
// shared constants and types for the decimal float string scanner
// ----------------------------------------------------------------------------
package dfss_pkg;

    // default sizes of the internal accumulators
    localparam int DFSS_MANT_BITS = 64;
    localparam int DFSS_EXP_BITS  = 16;

    // fixed widths of the result fields
    localparam int OUT_MANT_W = 64;
    localparam int OUT_EXP_W  = 16;
    // widest exponent accumulator plus margin for sign extension
    localparam int EXP_EXT_W  = 32;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;

    // exponent sign codes
    typedef logic [1:0] t_esign;
    localparam t_esign ESIGN_NONE  = 2'd0;
    localparam t_esign ESIGN_PLUS  = 2'd1;
    localparam t_esign ESIGN_MINUS = 2'd2;

    // status flags handed from the scan core to the exponent stage
    typedef struct packed {
        logic   negative;
        t_esign esign;
        logic   sat;
    } t_scan_flags;

endpackage

// ===== sv/dfss_char_if.sv =====
// ----------------------------------------------------------------------------
// dfss_char_if
// character stream channel: one character or end marker per transfer
// ----------------------------------------------------------------------------
interface dfss_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

// ===== sv/dfss_result_if.sv =====
// ----------------------------------------------------------------------------
// dfss_result_if
// result channel: sign, integer mantissa and decimal exponent
// ----------------------------------------------------------------------------
interface dfss_result_if;
    logic               valid;
    logic               ready;
    logic               negative;
    logic [63:0]        mantissa;
    logic signed [15:0] dec_exponent;
    logic               overflow;

    modport source (output valid, output negative, output mantissa,
                    output dec_exponent, output overflow, input ready);
    modport sink   (input valid, input negative, input mantissa,
                    input dec_exponent, input overflow, output ready);
endinterface

// ===== sv/dfss_scan_core.sv =====
// ----------------------------------------------------------------------------
// dfss_scan_core
// per-character scan state and its update, registered on each step
// ----------------------------------------------------------------------------
module dfss_scan_core
    import dfss_pkg::*;
#(
    parameter int MANT_BITS = DFSS_MANT_BITS,
    parameter int EXP_BITS  = DFSS_EXP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_char_code,
    input  logic                  i_is_end,
    output logic [MANT_BITS-1:0]  o_mant,
    output logic [EXP_BITS-2:0]   o_exp_acc,
    output logic [EXP_BITS-2:0]   o_frac_count,
    output t_scan_flags           o_flags
);

    localparam int EA_W = EXP_BITS - 1;

    logic [MANT_BITS-1:0] r_mant,      n_mant;
    logic [EA_W-1:0]      r_exp_acc,   n_exp_acc;
    logic [EA_W-1:0]      r_frac,      n_frac;
    logic                 r_neg,       n_neg;
    logic                 r_dot,       n_dot;
    // set by the exponent marker; exponent digits follow from then on
    logic                 r_exp_mode,  n_exp_mode;
    t_esign               r_esign,     n_esign;
    logic                 r_digits,    n_digits;
    logic                 r_stopped,   n_stopped;
    logic                 r_sat,       n_sat;

    logic                 num_char;
    logic [3:0]           digit;
    logic [MANT_BITS+3:0] mant_x10;
    logic [EA_W+3:0]      exp_x10;
    logic                 mant_ovf;
    logic                 exp_ovf;

    assign num_char = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign digit    = i_char_code[3:0];

    // times ten as shift-add, with four guard bits to spot overflow
    assign mant_x10 = ({4'b0, r_mant} << 3) + ({4'b0, r_mant} << 1)
                    + (MANT_BITS+4)'(digit);
    assign exp_x10  = ({4'b0, r_exp_acc} << 3) + ({4'b0, r_exp_acc} << 1)
                    + (EA_W+4)'(digit);
    assign mant_ovf = |mant_x10[MANT_BITS+3:MANT_BITS];
    assign exp_ovf  = |exp_x10[EA_W+3:EA_W];

    always_comb begin
        n_mant     = r_mant;
        n_exp_acc  = r_exp_acc;
        n_frac     = r_frac;
        n_neg      = r_neg;
        n_dot      = r_dot;
        n_exp_mode = r_exp_mode;
        n_esign    = r_esign;
        n_digits   = r_digits;
        n_stopped  = r_stopped;
        n_sat      = r_sat;
        if (i_is_end) begin
            n_mant     = '0;
            n_exp_acc  = '0;
            n_frac     = '0;
            n_neg      = 1'b0;
            n_dot      = 1'b0;
            n_exp_mode = 1'b0;
            n_esign    = ESIGN_NONE;
            n_digits   = 1'b0;
            n_stopped  = 1'b0;
            n_sat      = 1'b0;
        end else if (!r_stopped) begin
            if (num_char) begin
                if (r_exp_mode) begin
                    if (exp_ovf) begin
                        n_exp_acc = '1;
                        n_sat     = 1'b1;
                    end else begin
                        n_exp_acc = exp_x10[EA_W-1:0];
                    end
                    if (r_esign == ESIGN_NONE) begin
                        n_esign = ESIGN_PLUS;
                    end
                end else begin
                    n_digits = 1'b1;
                    if (mant_ovf) begin
                        n_mant = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_mant = mant_x10[MANT_BITS-1:0];
                    end
                    if (r_dot) begin
                        if (&r_frac) begin
                            n_sat = 1'b1;
                        end else begin
                            n_frac = r_frac + 1'b1;
                        end
                    end
                end
            end else if (!r_digits) begin
                // leading characters: minus sign and dot, anything else clears both
                if (i_char_code == CH_MINUS) begin
                    n_neg = 1'b1;
                end else if (i_char_code == CH_DOT) begin
                    n_dot = 1'b1;
                end else begin
                    n_neg = 1'b0;
                    n_dot = 1'b0;
                end
            end else if (!r_dot && !r_exp_mode && i_char_code == CH_DOT) begin
                n_dot = 1'b1;
            end else if (!r_exp_mode
                         && (i_char_code == CH_LOW_E || i_char_code == CH_UP_E)) begin
                n_exp_mode = 1'b1;
            end else if (r_exp_mode && r_esign == ESIGN_NONE
                         && i_char_code == CH_PLUS) begin
                n_esign = ESIGN_PLUS;
            end else if (r_exp_mode && r_esign == ESIGN_NONE
                         && i_char_code == CH_MINUS) begin
                n_esign = ESIGN_MINUS;
            end else begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mant     <= '0;
            r_exp_acc  <= '0;
            r_frac     <= '0;
            r_neg      <= 1'b0;
            r_dot      <= 1'b0;
            r_exp_mode <= 1'b0;
            r_esign    <= ESIGN_NONE;
            r_digits   <= 1'b0;
            r_stopped  <= 1'b0;
            r_sat      <= 1'b0;
        end else if (i_step) begin
            r_mant     <= n_mant;
            r_exp_acc  <= n_exp_acc;
            r_frac     <= n_frac;
            r_neg      <= n_neg;
            r_dot      <= n_dot;
            r_exp_mode <= n_exp_mode;
            r_esign    <= n_esign;
            r_digits   <= n_digits;
            r_stopped  <= n_stopped;
            r_sat      <= n_sat;
        end
    end

    assign o_mant           = r_mant;
    assign o_exp_acc        = r_exp_acc;
    assign o_frac_count     = r_frac;
    assign o_flags.negative = r_neg;
    assign o_flags.esign    = r_esign;
    assign o_flags.sat      = r_sat;

    // a frozen scan ignores characters
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_is_end && r_stopped |=> $stable(r_mant) && $stable(r_exp_acc)
            && $stable(r_frac) && r_stopped)
        else $error("scan state changed after the scan stopped");

    // the end marker leaves the scan state clear
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_is_end |=> r_mant == '0 && r_frac == '0 && r_exp_acc == '0
            && !r_digits && !r_stopped && !r_sat)
        else $error("scan state not cleared after end marker");

    // mantissa, fraction count and exponent only move once a digit came in
    a_digits_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_digits |-> r_mant == '0 && r_frac == '0 && !r_exp_mode && !r_stopped)
        else $error("scan progressed without a mantissa digit");

endmodule

// ===== sv/dfss_exp_final.sv =====
// ----------------------------------------------------------------------------
// dfss_exp_final
// combines exponent accumulator, its sign and the fraction count, with clamp
// ----------------------------------------------------------------------------
module dfss_exp_final
    import dfss_pkg::*;
#(
    parameter int EXP_BITS = DFSS_EXP_BITS
) (
    input  logic [EXP_BITS-2:0]   i_exp_acc,
    input  logic [EXP_BITS-2:0]   i_frac_count,
    input  t_scan_flags           i_flags,
    output logic [OUT_EXP_W-1:0]  o_dec_exponent,
    output logic                  o_overflow
);

    logic signed [EXP_BITS:0]     acc_s;
    logic signed [EXP_BITS:0]     term;
    logic signed [EXP_BITS:0]     diff;
    logic                         underflow;
    logic signed [EXP_BITS-1:0]   clamped;
    logic signed [EXP_EXT_W-1:0]  ext;

    assign acc_s = signed'({2'b00, i_exp_acc});

    always_comb begin
        case (i_flags.esign)
            ESIGN_PLUS:  term = acc_s;
            ESIGN_MINUS: term = -acc_s;
            default:     term = '0;
        endcase
    end

    assign diff = term - signed'({2'b00, i_frac_count});

    // the upper bound cannot be passed; only the low side needs a clamp
    assign underflow = diff[EXP_BITS] != diff[EXP_BITS-1];
    assign clamped   = underflow ? signed'({1'b1, {(EXP_BITS-1){1'b0}}})
                                 : diff[EXP_BITS-1:0];
    assign ext       = EXP_EXT_W'(clamped);

    assign o_dec_exponent = ext[OUT_EXP_W-1:0];
    assign o_overflow     = i_flags.sat | underflow;

endmodule

// ===== sv/decimal_float_string_scanner.sv =====
// ----------------------------------------------------------------------------
// decimal_float_string_scanner
// scans a decimal number string and reports sign, mantissa and exponent
// ----------------------------------------------------------------------------
// usage
//   i_char   : one transfer per character; is_end marks the end of a string,
//              its char_code is ignored
//   o_result : one transfer per end marker: value = +/- mantissa * 10^dec_exponent,
//              overflow flags a saturated mantissa or exponent
//   throughput: one character per cycle, end markers too while the result register is free
//   path: an end marker goes through the input register, then the result
//         register, which loads as the scan state clears
//   the per-character update is a times-ten shift-add on the mantissa or
//   exponent accumulator plus flag logic, combinational before the scan state register
//   reset: input and result registers empty, scan state clear
//   stall: a held result does not block characters; only a new end marker
//          waits in the input register, and then i_char.ready drops
// ----------------------------------------------------------------------------
module decimal_float_string_scanner
    import dfss_pkg::*;
#(
    parameter int MANT_BITS = DFSS_MANT_BITS,
    parameter int EXP_BITS  = DFSS_EXP_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dfss_char_if.sink       i_char,
    dfss_result_if.source   o_result
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // result register
    logic                  r_out_valid;
    logic                  r_out_neg;
    logic [OUT_MANT_W-1:0] r_out_mant;
    logic [OUT_EXP_W-1:0]  r_out_exp;
    logic                  r_out_ovf;

    logic                  out_free;
    logic                  advance;
    logic                  in_ready;

    logic [MANT_BITS-1:0]  w_mant;
    logic [EXP_BITS-2:0]   w_exp_acc;
    logic [EXP_BITS-2:0]   w_frac;
    t_scan_flags           w_flags;
    logic [OUT_EXP_W-1:0]  w_dec_exp;
    logic                  w_ovf;

    // characters always move on; an end marker needs a free result register
    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = r_in_valid && (!r_in_end || out_free);
    assign in_ready = !r_in_valid || advance;

    assign i_char.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
            r_in_end  <= i_char.is_end;
        end
    end

    dfss_scan_core #(
        .MANT_BITS (MANT_BITS),
        .EXP_BITS  (EXP_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_char_code  (r_in_char),
        .i_is_end     (r_in_end),
        .o_mant       (w_mant),
        .o_exp_acc    (w_exp_acc),
        .o_frac_count (w_frac),
        .o_flags      (w_flags)
    );

    dfss_exp_final #(
        .EXP_BITS (EXP_BITS)
    ) u_exp (
        .i_exp_acc      (w_exp_acc),
        .i_frac_count   (w_frac),
        .i_flags        (w_flags),
        .o_dec_exponent (w_dec_exp),
        .o_overflow     (w_ovf)
    );

    // result valid: loaded by an end marker, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // scan state still holds the whole string when the end marker steps
    always_ff @(posedge i_clk) begin
        if (advance && r_in_end) begin
            r_out_neg  <= w_flags.negative;
            r_out_mant <= OUT_MANT_W'(w_mant);
            r_out_exp  <= w_dec_exp;
            r_out_ovf  <= w_ovf;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.negative     = r_out_neg;
    assign o_result.mantissa     = r_out_mant;
    assign o_result.dec_exponent = r_out_exp;
    assign o_result.overflow     = r_out_ovf;

    // a held end marker never steps into a result register that is still full
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |-> !(advance && r_in_end))
        else $error("result overwritten before transfer");

    // a pending item that could not step stays in the input register
    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_char) && $stable(r_in_end))
        else $error("pending input item lost");

    // a result appears only after an end marker stepped
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_end))
        else $error("result without end marker");

endmodule

// ===== tb/sv/tb_decimal_float_string_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_float_string_scanner
// self-checking bench for the decimal float string scanner
// ----------------------------------------------------------------------------
// number strings are sent one character per transfer, each closed by an end
// marker. a scoreboard keeps its own copy of the scan state, predicts sign,
// mantissa, exponent and overflow for every end marker and compares them
// with each result transfer in order. directed strings cover the corner
// cases, random strings (mostly well formed, some noise) do the bulk, and
// one short string with fraction digits drives the exponent past its floor
// ----------------------------------------------------------------------------
module tb_decimal_float_string_scanner;
    import dfss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 810;
    // longest legal quiet stretch is a sender gap plus a receiver stall
    // plus the pass through the input and result registers, well under the limit
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    // saturation points of the accumulators at the block's default sizes
    localparam logic [63:0] MANT_LIMIT = {64{1'b1}} >> (64 - DFSS_MANT_BITS);
    localparam longint EXP_LIMIT = (longint'(1) << (DFSS_EXP_BITS - 1)) - 1;
    localparam longint EXP_FLOOR = -EXP_LIMIT - 1;

    typedef struct packed {
        logic               negative;
        logic [63:0]        mantissa;
        logic signed [15:0] dec_exponent;
        logic               overflow;
    } t_scan_value;

    // ------------------------------------------------------------------------
    // scoreboard: shadow scan state plus the queue of values still owed
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        logic [63:0] mant;
        longint      exp_acc;
        longint      frac;
        bit          neg;
        bit          dot;
        bit          e_seen;
        bit          in_exp;
        t_esign      esign;
        bit          seen_digit;
        bit          stopped;
        bit          sat;

        t_scan_value owed_values[$];
        int          errors;
        int          taken;

        function new();
            errors  = 0;
            taken   = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mant       = '0;
            exp_acc    = 0;
            frac       = 0;
            neg        = 0;
            dot        = 0;
            e_seen     = 0;
            in_exp     = 0;
            esign      = ESIGN_NONE;
            seen_digit = 0;
            stopped    = 0;
            sat        = 0;
        endfunction

        task report_mismatch(input string what);
            $display("ERROR @%0t: %s", $realtime, what);
            errors++;
        endtask

        function void scan_char(input logic [7:0] c);
            int unsigned dig;
            dig = 0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                dig = 32'(c - CH_ZERO);
                if (in_exp) begin
                    if (exp_acc > (EXP_LIMIT - longint'(dig)) / 10) begin
                        exp_acc = EXP_LIMIT;
                        sat     = 1;
                    end else begin
                        exp_acc = exp_acc * 10 + longint'(dig);
                    end
                    if (esign == ESIGN_NONE) esign = ESIGN_PLUS;
                end else begin
                    seen_digit = 1;
                    if (mant > (MANT_LIMIT - 64'(dig)) / 10) begin
                        mant = MANT_LIMIT;
                        sat  = 1;
                    end else begin
                        mant = mant * 10 + 64'(dig);
                    end
                    if (dot) begin
                        if (frac >= EXP_LIMIT) begin
                            frac = EXP_LIMIT;
                            sat  = 1;
                        end else begin
                            frac++;
                        end
                    end
                end
            end else if (!seen_digit) begin
                if (c == CH_MINUS) begin
                    neg = 1;
                end else if (c == CH_DOT) begin
                    dot = 1;
                end else begin
                    dot = 0;
                    neg = 0;
                end
            end else if (!dot && c == CH_DOT && !in_exp) begin
                dot = 1;
            end else if (!e_seen && (c == CH_LOW_E || c == CH_UP_E)) begin
                e_seen = 1;
                in_exp = 1;
            end else if (e_seen && esign == ESIGN_NONE && c == CH_PLUS) begin
                esign = ESIGN_PLUS;
            end else if (e_seen && esign == ESIGN_NONE && c == CH_MINUS) begin
                esign = ESIGN_MINUS;
            end else begin
                stopped = 1;
            end
        endfunction

        function void close_number();
            longint      e;
            t_scan_value v;
            v.overflow = sat;
            e = (esign == ESIGN_MINUS) ? -exp_acc : exp_acc;
            if (esign == ESIGN_NONE) e = 0;
            e = e - frac;
            if (e > EXP_LIMIT) begin
                e          = EXP_LIMIT;
                v.overflow = 1;
            end else if (e < EXP_FLOOR) begin
                e          = EXP_FLOOR;
                v.overflow = 1;
            end
            v.negative     = neg;
            v.mantissa     = mant;
            v.dec_exponent = 16'(e);
            owed_values.push_back(v);
            clear_scan();
        endfunction

        // one accepted character transfer
        function void note_char(input logic [7:0] c, input logic end_mark);
            taken++;
            if (end_mark) begin
                close_number();
            end else if (!stopped) begin
                scan_char(c);
            end
        endfunction

        // one accepted result transfer
        task check_value(input t_scan_value got);
            t_scan_value want;
            if (owed_values.size() == 0) begin
                report_mismatch("result transfer with no value pending");
            end else begin
                want = owed_values.pop_front();
                if (got.negative !== want.negative)
                    report_mismatch($sformatf("negative got %0b want %0b",
                                              got.negative, want.negative));
                if (got.mantissa !== want.mantissa)
                    report_mismatch($sformatf("mantissa got %0d want %0d",
                                              got.mantissa, want.mantissa));
                if (got.dec_exponent !== want.dec_exponent)
                    report_mismatch($sformatf("dec_exponent got %0d want %0d",
                                              got.dec_exponent, want.dec_exponent));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b",
                                              got.overflow, want.overflow));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    dfss_char_if   char_bus ();
    dfss_result_if result_bus ();

    decimal_float_string_scanner dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    scan_scoreboard sb;

    // when set, neither side idles; used for whole strings at a time
    bit no_idle = 1'b0;

    // characters of the string being built, end marker not included
    logic [7:0] text_q[$];

    // ------------------------------------------------------------------------
    // monitors: sample both channels at the edge, before anything updates
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && char_bus.valid === 1'b1 && char_bus.ready === 1'b1)
            sb.note_char(char_bus.char_code, char_bus.is_end);
    end

    always @(posedge i_clk) begin
        t_scan_value got;
        got.negative     = result_bus.negative;
        got.mantissa     = result_bus.mantissa;
        got.dec_exponent = result_bus.dec_exponent;
        got.overflow     = result_bus.overflow;
        if (i_rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            sb.check_value(got);
    end

    // watchdog: ends the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((char_bus.valid === 1'b1 && char_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: stalls are drawn per result and start once one is held,
    // so back pressure really lands on a waiting result
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                result_bus.ready <= 1'b0;
                do @(posedge i_clk); while (result_bus.valid !== 1'b1);
                repeat (stall - 1) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge i_clk); while (result_bus.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // character side
    // ------------------------------------------------------------------------
    // valid stays high after a transfer; it only drops when a gap follows,
    // so it never gets two assignments in one step
    task automatic send_item(input logic [7:0] c, input logic end_mark);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        char_bus.is_end    <= end_mark;
        do @(posedge i_clk); while (char_bus.ready !== 1'b1);
    endtask

    // the whole buffered string, then its end marker with a junk code
    task automatic send_text();
        foreach (text_q[i]) send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the sender until every owed value has come back
    task automatic wait_for_results();
        char_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_values.size() != 0);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // characters that most often change the scan, plus any byte at all
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_ZERO + 8'($urandom_range(0, 9));
            1:       c = CH_MINUS;
            2:       c = CH_PLUS;
            3:       c = CH_DOT;
            4:       c = CH_LOW_E;
            5:       c = CH_UP_E;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // random string: mostly a well formed number with random content,
    // the rest pure noise
    task automatic build_random_text();
        int r;
        text_q.delete();
        if ($urandom_range(0, 9) < 7) begin
            // leading part: sign, junk before the sign, a bare dot, or nothing
            case ($urandom_range(0, 6))
                0: text_q.push_back(CH_MINUS);
                1: text_q.push_back(CH_PLUS);
                2: begin
                    text_q.push_back(noise_char());
                    text_q.push_back(CH_MINUS);
                end
                3: text_q.push_back(CH_DOT);
                default: ;
            endcase
            // mantissa digits: short, long enough to saturate, or at the edge
            r = $urandom_range(0, 19);
            if (r == 0) begin
                push_digits($urandom_range(19, 24));
            end else if (r == 1) begin
                push_text("1844674407370955161");
                push_digits($urandom_range(1, 2));
            end else begin
                push_digits($urandom_range(1, 6));
            end
            // fraction
            if ($urandom_range(0, 2) != 0) begin
                text_q.push_back(CH_DOT);
                push_digits(($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(0, 4));
            end
            // exponent: marker, optional sign, then no digits, short digits, or digits near and past the limit
            if ($urandom_range(0, 2) != 0) begin
                text_q.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                case ($urandom_range(0, 2))
                    0: text_q.push_back(CH_PLUS);
                    1: text_q.push_back(CH_MINUS);
                    default: ;
                endcase
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    push_digits($urandom_range(5, 7));
                end else if (r == 1) begin
                    push_text("3276");
                    push_digits(1);
                end else if (r == 2) begin
                    push_digits(0);
                end else begin
                    push_digits($urandom_range(1, 3));
                end
            end
            // trailing junk: stops the scan or slips in as a late sign
            if ($urandom_range(0, 4) == 0) begin
                text_q.push_back(noise_char());
                push_digits($urandom_range(0, 2));
            end
        end else begin
            r = $urandom_range(0, 10);
            for (int i = 0; i < r; i++) text_q.push_back(noise_char());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int base_taken;
        int strings_sent;

        sb = new();
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        char_bus.is_end    <= 1'b0;
        result_bus.ready   <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner strings
        // empty string
        text_q.delete();
        send_text();
        // negative zero
        text_q.delete();
        push_text("-0");
        send_text();
        // non-ascii byte before the sign clears, then the sign is taken
        text_q.delete();
        text_q.push_back(8'hFF);
        push_text("-7");
        send_text();
        // leading dot, upper case marker and explicit plus sign
        text_q.delete();
        push_text("-.5E+2");
        send_text();
        // exponent marker with no digits after it
        text_q.delete();
        push_text("9e");
        send_text();
        // a second exponent sign freezes the scan
        text_q.delete();
        push_text("1e+-2");
        send_text();
        wait_for_results();

        // random strings, with drains and no-idle stretches mixed in
        base_taken   = sb.taken;
        strings_sent = 0;
        while (sb.taken - base_taken < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 5) == 0);
            build_random_text();
            send_text();
            strings_sent++;
            if (strings_sent % 8 == 0) wait_for_results();
        end
        no_idle = 1'b0;
        wait_for_results();

        // largest negative exponent minus two fraction digits lands
        // just below the floor of the final value
        no_idle = 1'b1;
        text_q.delete();
        push_text("1.55e-32767");
        send_text();
        no_idle = 1'b0;

        // drain, then let the pipeline settle
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.owed_values.size() != 0)
            sb.report_mismatch($sformatf("%0d values never came out",
                                         sb.owed_values.size()));

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
